### hdl/qrs_pkg.sv
// Package for the quadratic real root solver.
// Holds default widths, root count codes and the pipeline control struct.
// No dependencies; every other file depends on it.
`default_nettype none

package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

  // advance enable and valid bit entering a pipeline section
  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctl_t;

endpackage

`default_nettype wire

### hdl/qrs_coef_if.sv
// Channel interfaces: coefficient input and root result.
// Depends on qrs_pkg for default widths.
`default_nettype none

interface qrs_coef_if #(
  parameter int W = qrs_pkg::COEF_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] coef_a;
  logic signed [W-1:0] coef_b;
  logic signed [W-1:0] coef_c;

  modport source(output valid, coef_a, coef_b, coef_c, input ready);
  modport sink(input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface qrs_root_if #(
  parameter int W = qrs_pkg::COEF_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic [1:0]          root_count;
  logic signed [W-1:0] root_plus;
  logic signed [W-1:0] root_minus;
  logic                saturated;

  modport source(output valid, root_count, root_plus, root_minus, saturated,
                 input ready);
  modport sink(input valid, root_count, root_plus, root_minus, saturated,
               output ready);
endinterface

`default_nettype wire

### hdl/qrs_sqrt_pipe.sv
// Pipelined integer square root, one root bit per register stage.
// Carries a side vector and a valid bit alongside. Depends on qrs_pkg.
`default_nettype none

module qrs_sqrt_pipe #(
  parameter int TPW    = 98,
  parameter int SIDE_W = 66
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire qrs_pkg::stage_ctl_t       ctl,
  input  wire logic [TPW-1:0]            rad,
  input  wire logic [SIDE_W-1:0]         side_in,
  output logic                           valid_out,
  output logic [TPW/2-1:0]               root,
  output logic [SIDE_W-1:0]              side_out
);
  import qrs_pkg::*;

  localparam int SW = TPW / 2;
  localparam int RW = SW + 2;

  logic [TPW-1:0]    t_q    [1:SW];
  logic [RW-1:0]     rem_q  [1:SW];
  logic [SW-1:0]     root_q [1:SW];
  logic [SIDE_W-1:0] side_q [1:SW];
  logic              vld_q  [1:SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [TPW-1:0]    t_p;
    logic [RW-1:0]     rem_p;
    logic [SW-1:0]     root_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;
    logic [RW-1:0]     rem_sh;
    logic [RW-1:0]     trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign t_p    = rad;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_in;
      assign vld_p  = ctl.valid;
    end else begin : g_next
      assign t_p    = t_q[k];
      assign rem_p  = rem_q[k];
      assign root_p = root_q[k];
      assign side_p = side_q[k];
      assign vld_p  = vld_q[k];
    end

    // bring down the next two radicand bits and try root bit one
    assign rem_sh = {rem_p[RW-3:0], t_p[TPW-1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (ctl.en) begin
        vld_q[k+1] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        t_q[k+1]    <= t_p << 2;
        rem_q[k+1]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k+1] <= {root_p[SW-2:0], ge};
        side_q[k+1] <= side_p;
      end
    end
  end

  assign valid_out = vld_q[SW];
  assign root      = root_q[SW];
  assign side_out  = side_q[SW];

endmodule

`default_nettype wire

### hdl/qrs_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Divides two dividends by one shared divisor. Depends on qrs_pkg.
`default_nettype none

module qrs_div_pipe #(
  parameter int NW     = 50,
  parameter int DW     = 33,
  parameter int SIDE_W = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire qrs_pkg::stage_ctl_t   ctl,
  input  wire logic [NW-1:0]         num_p,
  input  wire logic [NW-1:0]         num_m,
  input  wire logic [DW-1:0]         den,
  input  wire logic [SIDE_W-1:0]     side_in,
  output logic                       valid_out,
  output logic [NW-1:0]              quo_p,
  output logic [NW-1:0]              quo_m,
  output logic [SIDE_W-1:0]          side_out
);
  import qrs_pkg::*;

  localparam int RW = DW + 1;

  logic [NW-1:0]     np_q   [1:NW];
  logic [NW-1:0]     nm_q   [1:NW];
  logic [RW-1:0]     rp_q   [1:NW];
  logic [RW-1:0]     rm_q   [1:NW];
  logic [NW-1:0]     qp_q   [1:NW];
  logic [NW-1:0]     qm_q   [1:NW];
  logic [DW-1:0]     den_q  [1:NW];
  logic [SIDE_W-1:0] side_q [1:NW];
  logic              vld_q  [1:NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0]     np_p, nm_p, qp_p, qm_p;
    logic [RW-1:0]     rp_p, rm_p, rp_sh, rm_sh, dext;
    logic [DW-1:0]     den_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p, gp, gm;

    if (k == 0) begin : g_first
      assign np_p   = num_p;
      assign nm_p   = num_m;
      assign rp_p   = '0;
      assign rm_p   = '0;
      assign qp_p   = '0;
      assign qm_p   = '0;
      assign den_p  = den;
      assign side_p = side_in;
      assign vld_p  = ctl.valid;
    end else begin : g_next
      assign np_p   = np_q[k];
      assign nm_p   = nm_q[k];
      assign rp_p   = rp_q[k];
      assign rm_p   = rm_q[k];
      assign qp_p   = qp_q[k];
      assign qm_p   = qm_q[k];
      assign den_p  = den_q[k];
      assign side_p = side_q[k];
      assign vld_p  = vld_q[k];
    end

    assign dext  = {1'b0, den_p};
    assign rp_sh = {rp_p[DW-1:0], np_p[NW-1]};
    assign rm_sh = {rm_p[DW-1:0], nm_p[NW-1]};
    assign gp    = (rp_sh >= dext);
    assign gm    = (rm_sh >= dext);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k+1] <= 1'b0;
      end else if (ctl.en) begin
        vld_q[k+1] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        np_q[k+1]   <= np_p << 1;
        nm_q[k+1]   <= nm_p << 1;
        rp_q[k+1]   <= gp ? rp_sh - dext : rp_sh;
        rm_q[k+1]   <= gm ? rm_sh - dext : rm_sh;
        qp_q[k+1]   <= {qp_p[NW-2:0], gp};
        qm_q[k+1]   <= {qm_p[NW-2:0], gm};
        den_q[k+1]  <= den_p;
        side_q[k+1] <= side_p;
      end
    end
  end

  assign valid_out = vld_q[NW];
  assign quo_p     = qp_q[NW];
  assign quo_m     = qm_q[NW];
  assign side_out  = side_q[NW];

endmodule

`default_nettype wire

### hdl/quadratic_real_root_solver.sv
// Top level of the quadratic real root solver: products, discriminant,
// square root and division pipelines, clamp. Uses qrs_pkg, qrs_coef_if,
// qrs_root_if, qrs_sqrt_pipe and qrs_div_pipe.
//
//   channel  modport  payload
//   coefs    sink     coef_a, coef_b, coef_c (signed, COEF_WIDTH)
//   roots    source   root_count, root_plus, root_minus, saturated
//
// One coefficient set enters per cycle unless an untaken result waits.
// Registers in order: products, discriminant, square root stages (SW =
// root bits), numerators, divider stages (NMW = quotient bits), output.
// The bit-per-stage chains set most of the depth. rst clears every valid
// bit. A stalled result freezes the whole pipeline; nothing is dropped.
`default_nettype none

module quadratic_real_root_solver #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  qrs_coef_if.sink   coefs,
  qrs_root_if.source roots
);
  import qrs_pkg::*;

  localparam int W    = COEF_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = 2 * W + 1;
  localparam int TW   = DW + 2 * F;
  localparam int SW   = (TW + 1) / 2;
  localparam int TPW  = 2 * SW;
  localparam int NMW  = ((W + F > SW) ? W + F : SW) + 1;
  localparam int NS   = NMW + 1;
  localparam int DENW = W + 1;
  localparam int SQ_SIDE = 2 + 2 * W;
  localparam int DV_SIDE = 4;
  localparam logic [NMW-1:0] MAXQ = NMW'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [NMW-1:0] MINQ = NMW'(64'd1 << (W - 1));

  logic       en;
  stage_ctl_t ctl;

  assign en          = !roots.valid || roots.ready;
  assign coefs.ready = en;

  // products
  logic [W-1:0]        ma, mb, mc;
  logic                v_a, opp_a;
  logic signed [W-1:0] a_a, b_a;
  logic [2*W-1:0]      bb_a, ac_a;

  assign ma = coefs.coef_a[W-1] ? -coefs.coef_a : coefs.coef_a;
  assign mb = coefs.coef_b[W-1] ? -coefs.coef_b : coefs.coef_b;
  assign mc = coefs.coef_c[W-1] ? -coefs.coef_c : coefs.coef_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
    end else if (en) begin
      v_a <= coefs.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_a   <= coefs.coef_a;
      b_a   <= coefs.coef_b;
      bb_a  <= (2*W)'(mb) * (2*W)'(mb);
      ac_a  <= (2*W)'(ma) * (2*W)'(mc);
      opp_a <= (coefs.coef_a[W-1] ^ coefs.coef_c[W-1]) &&
               (coefs.coef_a != '0) && (coefs.coef_c != '0);
    end
  end

  // discriminant
  logic [2*W+1:0]      bbx, fourp, dsum;
  logic                d_pos, d_zero;
  logic [1:0]          cnt_c;
  logic                v_b;
  logic [TPW-1:0]      rad_b;
  logic [1:0]          cnt_b;
  logic signed [W-1:0] a_b, b_b;

  always_comb begin
    bbx    = {2'b00, bb_a};
    fourp  = {ac_a, 2'b00};
    d_pos  = 1'b0;
    d_zero = 1'b0;
    dsum   = '0;
    if (opp_a) begin
      dsum  = bbx + fourp;
      d_pos = 1'b1;
    end else if (fourp < bbx) begin
      dsum  = bbx - fourp;
      d_pos = 1'b1;
    end else if (fourp == bbx) begin
      d_zero = 1'b1;
    end
    if (a_a == '0) begin
      cnt_c = CNT_NONE;
    end else if (d_pos) begin
      cnt_c = CNT_TWO;
    end else if (d_zero) begin
      cnt_c = CNT_ONE;
    end else begin
      cnt_c = CNT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b <= 1'b0;
    end else if (en) begin
      v_b <= v_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_b <= d_pos ? (TPW'(dsum[DW-1:0]) << (2 * F)) : '0;
      cnt_b <= cnt_c;
      a_b   <= a_a;
      b_b   <= b_a;
    end
  end

  // square root
  logic               v_s;
  logic [SW-1:0]      s_root;
  logic [SQ_SIDE-1:0] s_side;

  assign ctl.en    = en;
  assign ctl.valid = v_b;

  qrs_sqrt_pipe #(.TPW(TPW), .SIDE_W(SQ_SIDE)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rad      (rad_b),
    .side_in  ({cnt_b, a_b, b_b}),
    .valid_out(v_s),
    .root     (s_root),
    .side_out (s_side)
  );

  // numerators and divisor
  logic signed [W-1:0]  a_s, b_s;
  logic [1:0]           cnt_s;
  logic signed [NS-1:0] base, sx, np, nm;
  logic [NS-1:0]        np_abs, nm_abs;
  logic [W-1:0]         ma_s;
  logic                 v_n, negp_n, negm_n;
  logic [1:0]           cnt_n;
  logic [NMW-1:0]       np_n, nm_n;
  logic [DENW-1:0]      den_n;
  stage_ctl_t           ctl_d;

  assign cnt_s  = s_side[SQ_SIDE-1 -: 2];
  assign a_s    = s_side[2*W-1:W];
  assign b_s    = s_side[W-1:0];
  assign base   = -(NS'(b_s) <<< F);
  assign sx     = signed'({{(NS-SW){1'b0}}, s_root});
  assign np     = base + sx;
  assign nm     = base - sx;
  assign np_abs = np[NS-1] ? -np : np;
  assign nm_abs = nm[NS-1] ? -nm : nm;
  assign ma_s   = a_s[W-1] ? -a_s : a_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_n <= 1'b0;
    end else if (en) begin
      v_n <= v_s;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      np_n   <= np_abs[NMW-1:0];
      nm_n   <= nm_abs[NMW-1:0];
      den_n  <= {ma_s, 1'b0};
      negp_n <= np[NS-1] ^ a_s[W-1];
      negm_n <= nm[NS-1] ^ a_s[W-1];
      cnt_n  <= cnt_s;
    end
  end

  // division
  logic               v_q;
  logic [NMW-1:0]     qp, qm;
  logic [DV_SIDE-1:0] q_side;

  assign ctl_d.en    = en;
  assign ctl_d.valid = v_n;

  qrs_div_pipe #(.NW(NMW), .DW(DENW), .SIDE_W(DV_SIDE)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl_d),
    .num_p    (np_n),
    .num_m    (nm_n),
    .den      (den_n),
    .side_in  ({cnt_n, negp_n, negm_n}),
    .valid_out(v_q),
    .quo_p    (qp),
    .quo_m    (qm),
    .side_out (q_side)
  );

  // sign, clamp, output register
  logic [W-1:0] rp_c, rm_c;
  logic         satp, satm;

  always_comb begin
    satp = 1'b0;
    satm = 1'b0;
    if (q_side[1]) begin
      if (qp > MINQ) begin
        rp_c = {1'b1, {(W-1){1'b0}}};
        satp = 1'b1;
      end else begin
        rp_c = W'(-qp);
      end
    end else if (qp > MAXQ) begin
      rp_c = {1'b0, {(W-1){1'b1}}};
      satp = 1'b1;
    end else begin
      rp_c = qp[W-1:0];
    end
    if (q_side[0]) begin
      if (qm > MINQ) begin
        rm_c = {1'b1, {(W-1){1'b0}}};
        satm = 1'b1;
      end else begin
        rm_c = W'(-qm);
      end
    end else if (qm > MAXQ) begin
      rm_c = {1'b0, {(W-1){1'b1}}};
      satm = 1'b1;
    end else begin
      rm_c = qm[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roots.valid <= 1'b0;
    end else if (en) begin
      roots.valid <= v_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roots.root_count <= q_side[3:2];
      if (q_side[3:2] == CNT_NONE) begin
        roots.root_plus  <= '0;
        roots.root_minus <= '0;
        roots.saturated  <= 1'b0;
      end else begin
        roots.root_plus  <= rp_c;
        roots.root_minus <= rm_c;
        roots.saturated  <= satp || satm;
      end
    end
  end

  // checks
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.root_count == CNT_NONE |->
      roots.root_plus == '0 && roots.root_minus == '0 && !roots.saturated)
    else $error("no-root result carries nonzero fields");

  a_double_same: assert property (@(posedge clk) disable iff (rst)
    roots.valid && roots.root_count == CNT_ONE |->
      roots.root_plus == roots.root_minus)
    else $error("double root differs between fields");

  // hold a waiting transaction unchanged until it is taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    roots.valid && !roots.ready |=>
      roots.valid && $stable(roots.root_count) && $stable(roots.root_plus) &&
      $stable(roots.root_minus) && $stable(roots.saturated))
    else $error("waiting result changed before it was taken");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    roots.valid |-> roots.root_count == CNT_NONE ||
      roots.root_count == CNT_ONE || roots.root_count == CNT_TWO)
    else $error("root count out of range");

endmodule

`default_nettype wire
